FILE: rtl/bchm_pkg.sv
`default_nettype none

package bchm_pkg;

  // Field widths
  localparam int MV_W    = 13;
  localparam int LUX_W   = 16;
  localparam int SLEEP_W = 17;
  localparam int PCT_W   = 7;
  localparam int DIFF_W  = 14;
  localparam int CODE_W  = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Packed stream widths (whole bytes)
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPTIMAL_MV  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MV      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT_MV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NIGHT_LUX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HARVEST_LUX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_SLEEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_SLEEP  = 3'd6;

  // Reset values
  localparam logic [MV_W-1:0]    RST_OPTIMAL_MV  = 13'd3300;
  localparam logic [MV_W-1:0]    RST_LOW_MV      = 13'd3100;
  localparam logic [MV_W-1:0]    RST_FLOAT_MV    = 13'd3380;
  localparam logic [LUX_W-1:0]   RST_NIGHT_LUX   = 16'd10;
  localparam logic [LUX_W-1:0]   RST_HARVEST_LUX = 16'd1000;
  localparam logic [SLEEP_W-1:0] RST_LOW_SLEEP   = 17'd1800;
  localparam logic [SLEEP_W-1:0] RST_CRIT_SLEEP  = 17'd3600;
  localparam logic [MV_W-1:0]    RST_PREV_MV     = 13'd3300;

  // Charge table breakpoints (mV)
  localparam logic [MV_W-1:0] BP_FULL = 13'd3400;
  localparam logic [MV_W-1:0] BP_90   = 13'd3330;
  localparam logic [MV_W-1:0] BP_70   = 13'd3300;
  localparam logic [MV_W-1:0] BP_40   = 13'd3250;
  localparam logic [MV_W-1:0] BP_20   = 13'd3200;
  localparam logic [MV_W-1:0] BP_10   = 13'd3100;
  localparam logic [MV_W-1:0] BP_5    = 13'd3000;
  localparam logic [MV_W-1:0] BP_0    = 13'd2500;

  // Voltage code
  localparam logic [MV_W-1:0]   CODE_TOP_MV = 13'd3760;
  localparam logic [CODE_W-1:0] CODE_MAX    = 6'h3F;

  // Reciprocal multipliers: floor(x/c) = (x*M) >> S, exact over each range used
  localparam logic [10:0] M_DIV7   = 11'd74;    // x < 70
  localparam int          S_DIV7   = 9;
  localparam logic [10:0] M_DIV3   = 11'd86;    // x < 60
  localparam int          S_DIV3   = 8;
  localparam logic [10:0] M_DIV5A  = 11'd205;   // x < 150
  localparam int          S_DIV5A  = 10;
  localparam logic [10:0] M_DIV5B  = 11'd103;   // x < 100
  localparam int          S_DIV5B  = 9;
  localparam logic [10:0] M_DIV10  = 11'd103;   // x < 100
  localparam int          S_DIV10  = 10;
  localparam logic [10:0] M_DIV20A = 11'd103;   // x < 100
  localparam int          S_DIV20A = 11;
  localparam logic [10:0] M_DIV100 = 11'd656;   // x < 500
  localparam int          S_DIV100 = 16;
  localparam logic [10:0] M_DIV20B = 11'd1639;  // x < 1260
  localparam int          S_DIV20B = 15;

  // Health classes
  localparam logic [1:0] HEALTH_OPTIMAL  = 2'd0;
  localparam logic [1:0] HEALTH_LOW      = 2'd1;
  localparam logic [1:0] HEALTH_CRITICAL = 2'd2;

  // Solar classes
  localparam logic [1:0] SOLAR_NIGHT   = 2'd0;
  localparam logic [1:0] SOLAR_FLOAT   = 2'd1;
  localparam logic [1:0] SOLAR_HARVEST = 2'd2;
  localparam logic [1:0] SOLAR_DISCHG  = 2'd3;

  typedef struct packed {
    logic [MV_W-1:0]    optimal_mv;
    logic [MV_W-1:0]    low_mv;
    logic [MV_W-1:0]    float_mv;
    logic [LUX_W-1:0]   night_lux;
    logic [LUX_W-1:0]   harvest_lux;
    logic [SLEEP_W-1:0] low_sleep;
    logic [SLEEP_W-1:0] crit_sleep;
  } cfg_t;

  typedef struct packed {
    logic [MV_W-1:0]    battery_mv;
    logic [LUX_W-1:0]   light_level;
    logic [SLEEP_W-1:0] nominal_sleep;
    logic               sensor_fault;
    logic               reset_seen;
  } in_item_t;

  typedef struct packed {
    logic [PCT_W-1:0]   charge_percent;
    logic [1:0]         health_class;
    logic               throttle_needed;
    logic [DIFF_W-1:0]  voltage_change;
    logic [1:0]         solar_class;
    logic [SLEEP_W-1:0] advised_sleep;
    logic [7:0]         payload_byte;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/bchm_cfg_regs.sv
`default_nettype none

module bchm_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            wr_en,
  input  wire logic [bchm_pkg::CFG_IDX_W-1:0]  wr_idx,
  input  wire logic [bchm_pkg::CFG_DATA_W-1:0] wr_data,
  output bchm_pkg::cfg_t                       cfg
);

  bchm_pkg::cfg_t cfg_r;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.optimal_mv  <= bchm_pkg::RST_OPTIMAL_MV;
      cfg_r.low_mv      <= bchm_pkg::RST_LOW_MV;
      cfg_r.float_mv    <= bchm_pkg::RST_FLOAT_MV;
      cfg_r.night_lux   <= bchm_pkg::RST_NIGHT_LUX;
      cfg_r.harvest_lux <= bchm_pkg::RST_HARVEST_LUX;
      cfg_r.low_sleep   <= bchm_pkg::RST_LOW_SLEEP;
      cfg_r.crit_sleep  <= bchm_pkg::RST_CRIT_SLEEP;
    end else if (wr_en) begin
      case (wr_idx)
        bchm_pkg::REG_OPTIMAL_MV:  cfg_r.optimal_mv  <= wr_data[bchm_pkg::MV_W-1:0];
        bchm_pkg::REG_LOW_MV:      cfg_r.low_mv      <= wr_data[bchm_pkg::MV_W-1:0];
        bchm_pkg::REG_FLOAT_MV:    cfg_r.float_mv    <= wr_data[bchm_pkg::MV_W-1:0];
        bchm_pkg::REG_NIGHT_LUX:   cfg_r.night_lux   <= wr_data[bchm_pkg::LUX_W-1:0];
        bchm_pkg::REG_HARVEST_LUX: cfg_r.harvest_lux <= wr_data[bchm_pkg::LUX_W-1:0];
        bchm_pkg::REG_LOW_SLEEP:   cfg_r.low_sleep   <= wr_data[bchm_pkg::SLEEP_W-1:0];
        bchm_pkg::REG_CRIT_SLEEP:  cfg_r.crit_sleep  <= wr_data[bchm_pkg::SLEEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/bchm_eval.sv
`default_nettype none

module bchm_eval (
  input  wire bchm_pkg::cfg_t             cfg,
  input  wire bchm_pkg::in_item_t         item,
  input  wire logic [bchm_pkg::MV_W-1:0]  prev_mv,
  output bchm_pkg::out_item_t             res
);

  logic [bchm_pkg::MV_W-1:0]    v;
  logic [bchm_pkg::MV_W-1:0]    d90, d70, d40, d20, d10, d5, d0;
  logic [21:0]                  p90, p70, p40, p20, p10, p5, p0, pcode;
  logic [bchm_pkg::PCT_W-1:0]   charge;
  logic [1:0]                   health;
  logic [bchm_pkg::DIFF_W-1:0]  diff;
  logic                         rising;
  logic [1:0]                   solar;
  logic [bchm_pkg::SLEEP_W-1:0] sleep;
  logic [bchm_pkg::CODE_W-1:0]  code;
  logic [6:0]                   code_raw;

  assign v = item.battery_mv;

  // Segment offsets (only meaningful inside their own segment)
  assign d90 = v - bchm_pkg::BP_90;
  assign d70 = v - bchm_pkg::BP_70;
  assign d40 = v - bchm_pkg::BP_40;
  assign d20 = v - bchm_pkg::BP_20;
  assign d10 = v - bchm_pkg::BP_10;
  assign d5  = v - bchm_pkg::BP_5;
  assign d0  = v - bchm_pkg::BP_0;

  // Per-segment scaled quotients by reciprocal multiply
  assign p90   = 22'(d90[6:0])       * 22'(bchm_pkg::M_DIV7);
  assign p70   = 22'({d70[5:0], 1'b0}) * 22'(bchm_pkg::M_DIV3);
  assign p40   = 22'(d40[5:0] * 8'd3)  * 22'(bchm_pkg::M_DIV5A);
  assign p20   = 22'({d20[5:0], 1'b0}) * 22'(bchm_pkg::M_DIV5B);
  assign p10   = 22'(d10[6:0])       * 22'(bchm_pkg::M_DIV10);
  assign p5    = 22'(d5[6:0])        * 22'(bchm_pkg::M_DIV20A);
  assign p0    = 22'(d0[8:0])        * 22'(bchm_pkg::M_DIV100);
  assign pcode = 22'(d0[10:0])       * 22'(bchm_pkg::M_DIV20B);

  // Piecewise-linear charge select
  always_comb begin
    if (v >= bchm_pkg::BP_FULL)
      charge = 7'd100;
    else if (v >= bchm_pkg::BP_90)
      charge = 7'd90 + 7'(p90 >> bchm_pkg::S_DIV7);
    else if (v >= bchm_pkg::BP_70)
      charge = 7'd70 + 7'(p70 >> bchm_pkg::S_DIV3);
    else if (v >= bchm_pkg::BP_40)
      charge = 7'd40 + 7'(p40 >> bchm_pkg::S_DIV5A);
    else if (v >= bchm_pkg::BP_20)
      charge = 7'd20 + 7'(p20 >> bchm_pkg::S_DIV5B);
    else if (v >= bchm_pkg::BP_10)
      charge = 7'd10 + 7'(p10 >> bchm_pkg::S_DIV10);
    else if (v >= bchm_pkg::BP_5)
      charge = 7'd5 + 7'(p5 >> bchm_pkg::S_DIV20A);
    else if (v >= bchm_pkg::BP_0)
      charge = 7'(p0 >> bchm_pkg::S_DIV100);
    else
      charge = '0;
  end

  // Health thresholds
  always_comb begin
    if (v >= cfg.optimal_mv)  health = bchm_pkg::HEALTH_OPTIMAL;
    else if (v >= cfg.low_mv) health = bchm_pkg::HEALTH_LOW;
    else                      health = bchm_pkg::HEALTH_CRITICAL;
  end

  // Signed change from previous sample
  assign diff   = {1'b0, v} - {1'b0, prev_mv};
  assign rising = !diff[bchm_pkg::DIFF_W-1] && (diff != '0);

  // Solar class, first matching test wins
  always_comb begin
    if (item.light_level < cfg.night_lux)
      solar = bchm_pkg::SOLAR_NIGHT;
    else if (v >= cfg.float_mv)
      solar = bchm_pkg::SOLAR_FLOAT;
    else if (rising && (item.light_level >= cfg.harvest_lux))
      solar = bchm_pkg::SOLAR_HARVEST;
    else
      solar = bchm_pkg::SOLAR_DISCHG;
  end

  // Sleep clamp by health
  always_comb begin
    case (health)
      bchm_pkg::HEALTH_CRITICAL: sleep = cfg.crit_sleep;
      bchm_pkg::HEALTH_LOW:
        sleep = (item.nominal_sleep < cfg.low_sleep) ? cfg.low_sleep : item.nominal_sleep;
      default: sleep = item.nominal_sleep;
    endcase
  end

  // Six-bit voltage code, saturating
  assign code_raw = 7'(pcode >> bchm_pkg::S_DIV20B);
  always_comb begin
    if (v <= bchm_pkg::BP_0)
      code = '0;
    else if (v >= bchm_pkg::CODE_TOP_MV)
      code = bchm_pkg::CODE_MAX;
    else if (code_raw > 7'(bchm_pkg::CODE_MAX))
      code = bchm_pkg::CODE_MAX;
    else
      code = code_raw[bchm_pkg::CODE_W-1:0];
  end

  assign res.charge_percent  = charge;
  assign res.health_class    = health;
  assign res.throttle_needed = (health != bchm_pkg::HEALTH_OPTIMAL);
  assign res.voltage_change  = diff;
  assign res.solar_class     = solar;
  assign res.advised_sleep   = sleep;
  assign res.payload_byte    = {item.reset_seen, item.sensor_fault, code};

endmodule

`default_nettype wire

FILE: rtl/battery_charge_and_health_monitor.sv
`default_nettype none

// Battery monitor: each input beat (voltage, light, nominal sleep, two flags)
// yields one result beat with charge percent, health class and throttle flag,
// signed change from the previous sample, solar class, clamped sleep time and
// a packed telemetry byte. Throughput is one beat per clock unless out_tready
// stalls the output. An accepted beat sits in the input register, passes one
// combinational evaluation and lands in the result register, which drives
// out_tvalid, and leaves when out_tready is high. The
// previous-voltage state advances as a beat moves into the result register.
// Config writes are taken every cycle (cfg_ready is always high) and must
// only happen while the block is idle.

module battery_charge_and_health_monitor (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata, low bit up: battery_mv[12:0], light_level[28:13],
  // nominal_sleep[45:29], sensor_fault[46], reset_seen[47]
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [bchm_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata, low bit up: charge_percent[6:0], health_class[8:7],
  // throttle_needed[9], voltage_change[23:10], solar_class[25:24],
  // advised_sleep[42:26], payload_byte[50:43], zero fill[55:51]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [bchm_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bchm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bchm_pkg::CFG_DATA_W-1:0] cfg_data
);

  bchm_pkg::cfg_t      cfg;
  bchm_pkg::in_item_t  in_item;
  bchm_pkg::in_item_t  s1_item_r;
  bchm_pkg::out_item_t res;
  bchm_pkg::out_item_t s2_res_r;
  logic                s1_vld_r;
  logic                s2_vld_r;
  logic [bchm_pkg::MV_W-1:0] prev_mv_r;
  logic                adv;

  assign cfg_ready = 1'b1;

  bchm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // Unpack input beat
  assign in_item.battery_mv    = in_tdata[12:0];
  assign in_item.light_level   = in_tdata[28:13];
  assign in_item.nominal_sleep = in_tdata[45:29];
  assign in_item.sensor_fault  = in_tdata[46];
  assign in_item.reset_seen    = in_tdata[47];

  // Pipeline flow control
  assign adv       = !s2_vld_r || out_tready;
  assign in_tready = !s1_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      prev_mv_r <= bchm_pkg::RST_PREV_MV;
    end else begin
      if (in_tready) s1_vld_r <= in_tvalid;
      if (adv)       s2_vld_r <= s1_vld_r;
      if (adv && s1_vld_r) prev_mv_r <= s1_item_r.battery_mv;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) s1_item_r <= in_item;
    if (adv && s1_vld_r)        s2_res_r  <= res;
  end

  bchm_eval u_eval (
    .cfg     (cfg),
    .item    (s1_item_r),
    .prev_mv (prev_mv_r),
    .res     (res)
  );

  // Pack result beat
  assign out_tvalid = s2_vld_r;
  assign out_tdata  = {5'd0, s2_res_r.payload_byte, s2_res_r.advised_sleep,
                       s2_res_r.solar_class, s2_res_r.voltage_change,
                       s2_res_r.throttle_needed, s2_res_r.health_class,
                       s2_res_r.charge_percent};

endmodule

`default_nettype wire
